[hw/rtl/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSMA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSMA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rsma_pkg.sv]
// Types, constants and sequencer states of the run segment moment accumulator.
`default_nettype none

package rsma_pkg;

    localparam int unsigned IMAGE_SIDE = 1024;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned AREA_W  = 21;
    localparam int unsigned SUM_W   = 30;
    localparam int unsigned M11_W   = 41;
    localparam int unsigned MOM_W   = 40;

    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned REG_SEL_BIT = 2;

    // shared unit widths
    localparam int unsigned MUL_W  = 24;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned ADD_W  = 48;

    // intermediate widths
    localparam int unsigned T_W   = 21;  // n(n-1)/2
    localparam int unsigned F_W   = 20;  // factor after exact divide by 3
    localparam int unsigned SQ_W  = 32;  // (n-1)n(2n-1)/6
    localparam int unsigned S1_W  = 23;  // sum of row offsets
    localparam int unsigned TMP_W = 36;
    localparam int unsigned DD_W  = 21;  // squared offset

    // x/3 for small multiples of 3: (x*683)>>11
    localparam logic [MUL_W-1:0] RECIP3    = MUL_W'(683);
    localparam int unsigned      RECIP3_SH = 11;
    // inverse of 3 modulo 2^22, exact division of a multiple of 3
    localparam logic [MUL_W-1:0] INV3_22   = MUL_W'(2796203);

    localparam longint SIDE_L     = longint'(IMAGE_SIDE);
    localparam longint AREA_MAX_L = SIDE_L * SIDE_L;
    localparam longint SUM_MAX_L  = SIDE_L * SIDE_L * (SIDE_L - 1);
    localparam longint MOM_MAX_L  = SIDE_L * SIDE_L * (SIDE_L - 1) * (SIDE_L - 1);

    localparam logic signed [ADD_W-1:0] AREA_MAX = ADD_W'(AREA_MAX_L);
    localparam logic signed [ADD_W-1:0] SUM_MAX  = ADD_W'(SUM_MAX_L);
    localparam logic signed [ADD_W-1:0] MOM_MAX  = ADD_W'(MOM_MAX_L);
    localparam logic signed [ADD_W-1:0] MOM_MIN  = ADD_W'(-MOM_MAX_L);

    typedef enum logic [0:0] {
        REG_CENTRE_COL = 1'b0,
        REG_CENTRE_ROW = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] centre_col;
        logic [COORD_W-1:0] centre_row;
    } t_cfg;

    typedef struct packed {
        logic                    clamp;
        logic signed [ADD_W-1:0] lo;
        logic signed [ADD_W-1:0] hi;
    } t_add_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRI,
        ST_NCOL,
        ST_NB,
        ST_DIV3,
        ST_NA,
        ST_SQ,
        ST_CROSS,
        ST_DCDC,
        ST_NDD,
        ST_COLSQ,
        ST_BB,
        ST_NBB,
        ST_S2SUM,
        ST_ROWSQ,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/rsma_if.sv]
// Run input channel and moment result channel.
`default_nettype none

interface rsma_run_if import rsma_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] run_col;
    logic [COORD_W-1:0] run_first_row;
    logic [LEN_W-1:0]   run_len;
    logic               run_last;

    modport source (output valid, run_col, run_first_row, run_len, run_last, input ready);
    modport sink   (input valid, run_col, run_first_row, run_len, run_last, output ready);
endinterface

interface rsma_res_if import rsma_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [AREA_W-1:0]       area;
    logic [SUM_W-1:0]        sum_col;
    logic [SUM_W-1:0]        sum_row;
    logic signed [M11_W-1:0] central_m11;
    logic [MOM_W-1:0]        central_m20;
    logic [MOM_W-1:0]        central_m02;
    logic                    saturated;

    modport source (output valid, area, sum_col, sum_row, central_m11, central_m20,
                    central_m02, saturated, input ready);
    modport sink   (input valid, area, sum_col, sum_row, central_m11, central_m20,
                    central_m02, saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/rsma_cfg.sv]
// APB register block holding the centre coordinates.
`default_nettype none

module rsma_cfg import rsma_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTRE_COL: r_cfg.centre_col <= pwdata[COORD_W-1:0];
                REG_CENTRE_ROW: r_cfg.centre_row <= pwdata[COORD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CENTRE_COL: prdata = APB_DW'(r_cfg.centre_col);
            REG_CENTRE_ROW: prdata = APB_DW'(r_cfg.centre_row);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/rsma_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none

module rsma_mul import rsma_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic signed [MUL_W-1:0]  i_op_a,
    input  wire logic signed [MUL_W-1:0]  i_op_b,
    output logic signed      [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[hw/rtl/rsma_satadd.sv]
// Shared adder with optional clamp to a [lo, hi] window.
`default_nettype none

module rsma_satadd import rsma_pkg::*; (
    input  wire logic signed [ADD_W-1:0] i_a,
    input  wire logic signed [ADD_W-1:0] i_b,
    input  wire t_add_ctl                i_ctl,
    output logic signed      [ADD_W-1:0] o_sum,
    output logic                         o_clamped
);

    logic signed [ADD_W-1:0] w_raw;

    assign w_raw = i_a + i_b;

    always_comb begin
        o_sum     = w_raw;
        o_clamped = 1'b0;
        if (i_ctl.clamp) begin
            priority if (w_raw > i_ctl.hi) begin
                o_sum     = i_ctl.hi;
                o_clamped = 1'b1;
            end else if (w_raw < i_ctl.lo) begin
                o_sum     = i_ctl.lo;
                o_clamped = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/run_segment_moment_accumulator.sv]
// Top level: sequencer, accumulators and result register of the moment accumulator.
`default_nettype none

// Accumulates area, column and row sums and the central moments m11, m20, m02
// of a region given as vertical runs. After its accept cycle each run passes
// through 15 sequencer steps that share one 24x24 multiplier (at most one
// product per step) and one saturating adder; i_run.ready is high only in
// between. The run marked last stays in its final step for as long as the
// result register still holds an earlier result that has not been taken,
// and leaves it in the cycle that result is taken.
// The result register lets the next run be accepted while a result waits.
// Central moments use the centre registers at the time the run is accepted;
// write them only while the block is idle.

module run_segment_moment_accumulator import rsma_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    rsma_run_if.sink               i_run,
    rsma_res_if.source             o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    function automatic logic [1:0] mod3_len(input logic [LEN_W-1:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        // base-4 digit sums, 4 is 1 mod 3
        s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8])
           + 5'(v[10]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        if (s2 >= 3'd6) begin
            s2 = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            s2 = s2 - 3'd3;
        end
        return s2[1:0];
    endfunction

    t_cfg w_cfg;

    t_state r_state, n_state;

    // item registers
    logic [LEN_W-1:0]          r_n;
    logic [COORD_W-1:0]        r_col;
    logic [COORD_W-1:0]        r_a;
    logic                      r_last;
    logic signed [COORD_W:0]   r_dc;
    logic signed [COORD_W:0]   r_b;
    logic [T_W-1:0]            r_t;
    logic [F_W-1:0]            r_f;
    logic [SQ_W-1:0]           r_sq;
    logic signed [S1_W-1:0]    r_s1;
    logic signed [TMP_W-1:0]   r_tmp;

    // accumulators
    logic [AREA_W-1:0]         r_area;
    logic [SUM_W-1:0]          r_csum;
    logic [SUM_W-1:0]          r_rsum;
    logic signed [M11_W-1:0]   r_m11;
    logic [MOM_W-1:0]          r_m20;
    logic [MOM_W-1:0]          r_m02;
    logic                      r_sat;

    // result register
    logic                      r_out_valid;
    logic [AREA_W-1:0]         r_res_area;
    logic [SUM_W-1:0]          r_res_csum;
    logic [SUM_W-1:0]          r_res_rsum;
    logic signed [M11_W-1:0]   r_res_m11;
    logic [MOM_W-1:0]          r_res_m20;
    logic [MOM_W-1:0]          r_res_m02;
    logic                      r_res_sat;

    logic                      w_accept;
    logic                      w_emit;
    logic                      w_mod2;
    logic signed [LEN_W:0]     w_nm1;
    logic signed [LEN_W+1:0]   w_2nm1;
    logic signed [MUL_W-1:0]   w_n_op;
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ADD_W-1:0]   w_add_a, w_add_b, w_sum;
    t_add_ctl                  w_add_ctl;
    logic                      w_clamped;

    rsma_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rsma_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_mul_a),
        .i_op_b (w_mul_b),
        .o_prod (w_prod)
    );

    rsma_satadd u_add (
        .i_a       (w_add_a),
        .i_b       (w_add_b),
        .i_ctl     (w_add_ctl),
        .o_sum     (w_sum),
        .o_clamped (w_clamped)
    );

    assign i_run.ready = (r_state == ST_IDLE);
    assign w_accept    = i_run.valid && i_run.ready;
    assign w_mod2      = (mod3_len(r_n) == 2'd2);
    assign w_nm1       = $signed({1'b0, r_n}) - (LEN_W+1)'(1);
    assign w_2nm1      = $signed({1'b0, r_n, 1'b0}) - (LEN_W+2)'(1);
    assign w_n_op      = $signed(MUL_W'(r_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: each step issues at most one product and may add an earlier result
    always_comb begin
        n_state   = r_state;
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_add_a   = '0;
        w_add_b   = '0;
        w_add_ctl = '{clamp: 1'b0, lo: '0, hi: '0};
        w_emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_TRI;
                end
            end
            ST_TRI: begin
                w_mul_a   = w_n_op;
                w_mul_b   = MUL_W'(w_nm1);
                w_add_a   = $signed(ADD_W'(r_area));
                w_add_b   = $signed(ADD_W'(r_n));
                w_add_ctl = '{clamp: 1'b1, lo: '0, hi: AREA_MAX};
                n_state   = ST_NCOL;
            end
            ST_NCOL: begin
                w_mul_a = w_n_op;
                w_mul_b = $signed(MUL_W'(r_col));
                n_state = ST_NB;
            end
            ST_NB: begin
                w_mul_a   = w_n_op;
                w_mul_b   = MUL_W'(r_b);
                w_add_a   = $signed(ADD_W'(r_csum));
                w_add_b   = ADD_W'(w_prod);
                w_add_ctl = '{clamp: 1'b1, lo: '0, hi: SUM_MAX};
                n_state   = ST_DIV3;
            end
            ST_DIV3: begin
                if (w_mod2) begin
                    w_mul_a = MUL_W'(w_2nm1);
                    w_mul_b = $signed(RECIP3);
                end else begin
                    w_mul_a = $signed(MUL_W'(r_t));
                    w_mul_b = $signed(INV3_22);
                end
                w_add_a = ADD_W'(w_prod);
                w_add_b = $signed(ADD_W'(r_t));
                n_state = ST_NA;
            end
            ST_NA: begin
                w_mul_a = w_n_op;
                w_mul_b = $signed(MUL_W'(r_a));
                n_state = ST_SQ;
            end
            ST_SQ: begin
                if (w_mod2) begin
                    w_mul_a = $signed(MUL_W'(r_t));
                    w_mul_b = $signed(MUL_W'(r_f));
                end else begin
                    w_mul_a = $signed(MUL_W'(r_f));
                    w_mul_b = MUL_W'(w_2nm1);
                end
                w_add_a = ADD_W'(w_prod);
                w_add_b = $signed(ADD_W'(r_t));
                n_state = ST_CROSS;
            end
            ST_CROSS: begin
                w_mul_a   = MUL_W'(r_dc);
                w_mul_b   = MUL_W'(r_s1);
                w_add_a   = $signed(ADD_W'(r_rsum));
                w_add_b   = ADD_W'(r_tmp);
                w_add_ctl = '{clamp: 1'b1, lo: '0, hi: SUM_MAX};
                n_state   = ST_DCDC;
            end
            ST_DCDC: begin
                w_mul_a   = MUL_W'(r_dc);
                w_mul_b   = MUL_W'(r_dc);
                w_add_a   = ADD_W'(r_m11);
                w_add_b   = ADD_W'(w_prod);
                w_add_ctl = '{clamp: 1'b1, lo: MOM_MIN, hi: MOM_MAX};
                n_state   = ST_NDD;
            end
            ST_NDD: begin
                w_mul_a = w_n_op;
                w_mul_b = $signed(MUL_W'(w_prod[DD_W-1:0]));
                n_state = ST_COLSQ;
            end
            ST_COLSQ: begin
                w_mul_a   = MUL_W'(r_b);
                w_mul_b   = $signed(MUL_W'(r_t));
                w_add_a   = $signed(ADD_W'(r_m20));
                w_add_b   = ADD_W'(w_prod);
                w_add_ctl = '{clamp: 1'b1, lo: '0, hi: MOM_MAX};
                n_state   = ST_BB;
            end
            ST_BB: begin
                w_mul_a = MUL_W'(r_b);
                w_mul_b = MUL_W'(r_b);
                // 2*b*t + sq
                w_add_a = $signed({w_prod[ADD_W-2:0], 1'b0});
                w_add_b = $signed(ADD_W'(r_sq));
                n_state = ST_NBB;
            end
            ST_NBB: begin
                w_mul_a = w_n_op;
                w_mul_b = $signed(MUL_W'(w_prod[DD_W-1:0]));
                n_state = ST_S2SUM;
            end
            ST_S2SUM: begin
                w_add_a = ADD_W'(w_prod);
                w_add_b = ADD_W'(r_tmp);
                n_state = ST_ROWSQ;
            end
            ST_ROWSQ: begin
                w_add_a   = $signed(ADD_W'(r_m02));
                w_add_b   = ADD_W'(r_tmp);
                w_add_ctl = '{clamp: 1'b1, lo: '0, hi: MOM_MAX};
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || o_res.ready) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // item and intermediate registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_n    <= i_run.run_len;
                    r_col  <= i_run.run_col;
                    r_a    <= i_run.run_first_row;
                    r_last <= i_run.run_last;
                    r_dc   <= $signed({1'b0, i_run.run_col}) - $signed({1'b0, w_cfg.centre_col});
                    r_b    <= $signed({1'b0, i_run.run_first_row})
                            - $signed({1'b0, w_cfg.centre_row});
                end
            end
            ST_NCOL:  r_t  <= w_prod[T_W:1];
            ST_DIV3:  r_s1 <= $signed(w_sum[S1_W-1:0]);
            ST_NA:    r_f  <= w_mod2 ? F_W'(w_prod[RECIP3_SH+LEN_W-1:RECIP3_SH])
                                     : w_prod[F_W-1:0];
            ST_SQ:    r_tmp <= TMP_W'(w_sum);
            ST_CROSS: r_sq <= w_prod[SQ_W-1:0];
            ST_BB:    r_tmp <= TMP_W'(w_sum);
            ST_S2SUM: r_tmp <= TMP_W'(w_sum);
            default: ;
        endcase
    end

    // accumulators, cleared after the region's result is taken into the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= '0;
            r_csum <= '0;
            r_rsum <= '0;
            r_m11  <= '0;
            r_m20  <= '0;
            r_m02  <= '0;
            r_sat  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_TRI: begin
                    r_area <= w_sum[AREA_W-1:0];
                    r_sat  <= r_sat | w_clamped;
                end
                ST_NB: begin
                    r_csum <= w_sum[SUM_W-1:0];
                    r_sat  <= r_sat | w_clamped;
                end
                ST_CROSS: begin
                    r_rsum <= w_sum[SUM_W-1:0];
                    r_sat  <= r_sat | w_clamped;
                end
                ST_DCDC: begin
                    r_m11 <= $signed(w_sum[M11_W-1:0]);
                    r_sat <= r_sat | w_clamped;
                end
                ST_COLSQ: begin
                    r_m20 <= w_sum[MOM_W-1:0];
                    r_sat <= r_sat | w_clamped;
                end
                ST_ROWSQ: begin
                    r_m02 <= w_sum[MOM_W-1:0];
                    r_sat <= r_sat | w_clamped;
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_area <= '0;
                        r_csum <= '0;
                        r_rsum <= '0;
                        r_m11  <= '0;
                        r_m20  <= '0;
                        r_m02  <= '0;
                        r_sat  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res_area <= r_area;
            r_res_csum <= r_csum;
            r_res_rsum <= r_rsum;
            r_res_m11  <= r_m11;
            r_res_m20  <= r_m20;
            r_res_m02  <= r_m02;
            r_res_sat  <= r_sat;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.area        = r_res_area;
    assign o_res.sum_col     = r_res_csum;
    assign o_res.sum_row     = r_res_rsum;
    assign o_res.central_m11 = r_res_m11;
    assign o_res.central_m20 = r_res_m20;
    assign o_res.central_m02 = r_res_m02;
    assign o_res.saturated   = r_res_sat;

endmodule

`default_nettype wire

[hw/rtl/rsma_checker.sv]
// Port-level checks of the moment accumulator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module rsma_checker import rsma_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_run_valid,
    input wire logic               i_run_ready,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire logic [AREA_W-1:0]  i_res_area,
    input wire logic [MOM_W-1:0]   i_res_m20,
    input wire logic [MOM_W-1:0]   i_res_m02
);

    logic w_run_acc;

    assign w_run_acc = i_run_valid && i_run_ready;

    `RSMA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_run_acc, !i_run_ready, "ready stayed high after an item was accepted")
    `RSMA_ASSERT_NXT(a_no_fast_result, i_clk, i_rst_n, w_run_acc, !$rose(i_res_valid), "result appeared right after an accept")
    `RSMA_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_area), "stalled result changed")
    `RSMA_ASSERT_IMP(a_area_bound, i_clk, i_rst_n, i_res_valid, ADD_W'(i_res_area) <= AREA_MAX, "area above clamp limit")
    `RSMA_ASSERT_IMP(a_mom_bound, i_clk, i_rst_n, i_res_valid, (ADD_W'(i_res_m20) <= MOM_MAX) && (ADD_W'(i_res_m02) <= MOM_MAX), "second moment above clamp limit")

endmodule

bind run_segment_moment_accumulator rsma_checker u_rsma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_run_valid (i_run.valid),
    .i_run_ready (i_run.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_area  (o_res.area),
    .i_res_m20   (o_res.central_m20),
    .i_res_m02   (o_res.central_m02)
);

`default_nettype wire

[verif/rsma_moment_checker.sv]
// Scoreboard for the moment accumulator: tracks the centre registers, predicts region results, compares.
`default_nettype none

module rsma_moment_checker import rsma_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    rsma_run_if                    i_run,
    rsma_res_if                    i_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_region_count
);

    localparam longint SIDE     = longint'(IMAGE_SIDE);
    localparam longint AREA_TOP = SIDE * SIDE;
    localparam longint SUM_TOP  = SIDE * SIDE * (SIDE - 1);
    localparam longint MOM_TOP  = SUM_TOP * (SIDE - 1);

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0]  sum_col;
        logic [SUM_W-1:0]  sum_row;
        logic [M11_W-1:0]  central_m11;
        logic [MOM_W-1:0]  central_m20;
        logic [MOM_W-1:0]  central_m02;
        logic              saturated;
    } t_region_moments;

    t_region_moments    region_q[$];
    t_region_moments    exp_m;
    logic [COORD_W-1:0] ctr_col;
    logic [COORD_W-1:0] ctr_row;
    longint             area_acc;
    longint             col_sum_acc;
    longint             row_sum_acc;
    longint             cross_acc;
    longint             col_sq_acc;
    longint             row_sq_acc;
    bit                 clamped;
    int                 fails;
    int                 regions;

    function automatic longint clamp_add(input longint acc, input longint add,
                                         input longint lo, input longint hi, output bit hit);
        longint s;
        s   = acc + add;
        hit = 1'b0;
        if (s > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (s < lo) begin
            hit = 1'b1;
            return lo;
        end
        return s;
    endfunction

    function automatic void clear_sums();
        area_acc    = 0;
        col_sum_acc = 0;
        row_sum_acc = 0;
        cross_acc   = 0;
        col_sq_acc  = 0;
        row_sq_acc  = 0;
        clamped     = 1'b0;
    endfunction

    // Adds one run to the region sums; the run marked last closes the region.
    function automatic void fold_run(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                                     input logic [LEN_W-1:0] len, input logic last);
        longint          n;
        longint          d_col;
        longint          d_row;
        longint          ramp;
        longint          ramp_sq;
        longint          off_sum;
        longint          off_sq;
        bit [5:0]        hit;
        t_region_moments m;
        n       = longint'(len);
        d_col   = longint'(col) - longint'(ctr_col);
        d_row   = longint'(row) - longint'(ctr_row);
        ramp    = n * (n - 1) / 2;
        ramp_sq = (n - 1) * n * (2 * n - 1) / 6;
        off_sum = n * d_row + ramp;
        off_sq  = n * d_row * d_row + 2 * d_row * ramp + ramp_sq;

        area_acc    = clamp_add(area_acc, n, 0, AREA_TOP, hit[0]);
        col_sum_acc = clamp_add(col_sum_acc, n * longint'(col), 0, SUM_TOP, hit[1]);
        row_sum_acc = clamp_add(row_sum_acc, n * longint'(row) + ramp, 0, SUM_TOP, hit[2]);
        cross_acc   = clamp_add(cross_acc, d_col * off_sum, -MOM_TOP, MOM_TOP, hit[3]);
        col_sq_acc  = clamp_add(col_sq_acc, n * d_col * d_col, 0, MOM_TOP, hit[4]);
        row_sq_acc  = clamp_add(row_sq_acc, off_sq, 0, MOM_TOP, hit[5]);
        if (|hit) clamped = 1'b1;

        if (last) begin
            m.area        = AREA_W'(area_acc);
            m.sum_col     = SUM_W'(col_sum_acc);
            m.sum_row     = SUM_W'(row_sum_acc);
            m.central_m11 = M11_W'(cross_acc);
            m.central_m20 = MOM_W'(col_sq_acc);
            m.central_m02 = MOM_W'(row_sq_acc);
            m.saturated   = clamped;
            region_q.push_back(m);
            clear_sums();
        end
    endfunction

    function automatic void check_field(input string fname, input longint exp_v,
                                        input longint got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", fname, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctr_col = '0;
            ctr_row = '0;
            clear_sums();
            region_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[REG_SEL_BIT]))
                    REG_CENTRE_COL: ctr_col = pwdata[COORD_W-1:0];
                    REG_CENTRE_ROW: ctr_row = pwdata[COORD_W-1:0];
                    default: ;
                endcase
            end

            // results first: a result never belongs to a run accepted at the same edge
            if (i_res.valid && i_res.ready) begin
                if (region_q.size() == 0) begin
                    $error("region result arrived with nothing pending");
                    fails++;
                end else begin
                    exp_m = region_q.pop_front();
                    regions++;
                    check_field("area", exp_m.area, i_res.area);
                    check_field("sum_col", exp_m.sum_col, i_res.sum_col);
                    check_field("sum_row", exp_m.sum_row, i_res.sum_row);
                    check_field("central_m11", $signed(exp_m.central_m11),
                                $signed(i_res.central_m11));
                    check_field("central_m20", exp_m.central_m20, i_res.central_m20);
                    check_field("central_m02", exp_m.central_m02, i_res.central_m02);
                    check_field("saturated", exp_m.saturated, i_res.saturated);
                end
            end

            if (i_run.valid && i_run.ready)
                fold_run(i_run.run_col, i_run.run_first_row, i_run.run_len, i_run.run_last);
        end
        o_fail_count   <= fails;
        o_pending      <= region_q.size();
        o_region_count <= regions;
    end

endmodule

`default_nettype wire

[verif/testbench.sv]
// Top of the moment accumulator testbench: clock, reset, run and register stimulus, verdict.
`default_nettype none

module testbench;
    import rsma_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int LEN_MAX       = (1 << LEN_W) - 1;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rsma_run_if run_ch();
    rsma_res_if res_ch();

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int runs_sent;
    int centre_writes;
    int fail_count;
    int pending;
    int region_count;

    run_segment_moment_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rsma_moment_checker moments_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_run          (run_ch),
        .i_res          (res_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_region_count (region_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Result side: random stalls, plus long hold-offs on request.
    initial begin : result_sink
        int hold_left;
        int holds_taken;
        hold_left    = 0;
        holds_taken  = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_taken != hold_requests) begin
                holds_taken = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Ends the run if nothing moves on any port for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((run_ch.valid && run_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_run(input int col, input int row, input int len, input bit last);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            run_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
        run_ch.valid         <= 1'b1;
        run_ch.run_col       <= COORD_W'(col);
        run_ch.run_first_row <= COORD_W'(row);
        run_ch.run_len       <= LEN_W'(len);
        run_ch.run_last      <= last;
        do @(posedge i_clk); while (!run_ch.ready);
        runs_sent++;
    endtask

    task automatic stop_runs();
        @(negedge i_clk);
        run_ch.valid <= 1'b0;
    endtask

    // Wait for every region result, then let a run without a result finish.
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << REG_SEL_BIT;
        // upper data bits are junk; only the low coordinate bits count
        pwdata  <= (APB_DW'($urandom()) << COORD_W) | APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_centre(input int col, input int row);
        apb_write(REG_CENTRE_COL, col);
        apb_write(REG_CENTRE_ROW, row);
        centre_writes++;
    endtask

    // Regions of 1..12 runs; some zero-length, past the bottom edge, or stray last flags.
    task automatic send_regions(input int n_items);
        int sent;
        int span;
        int kind;
        int col;
        int row;
        int len;
        bit last;
        sent = 0;
        while (sent < n_items) begin
            span = $urandom_range(1, 12);
            for (int k = 0; k < span; k++) begin
                kind = $urandom_range(0, 99);
                col  = $urandom_range(0, COORD_MAX);
                row  = $urandom_range(0, COORD_MAX);
                last = (k == span - 1);
                if (kind < 70) begin
                    len = $urandom_range(1, IMAGE_SIDE - row);
                    if ($urandom_range(0, 3) != 0 && len > 64) len = $urandom_range(1, 64);
                end else if (kind < 80) begin
                    len = 0;
                end else if (kind < 90) begin
                    len = $urandom_range(IMAGE_SIDE - row, LEN_MAX);
                end else begin
                    len  = $urandom_range(0, LEN_MAX);
                    last = $urandom_range(0, 1);
                end
                send_run(col, row, len, last);
                sent++;
            end
        end
    endtask

    // One long region of near-maximum runs, enough to clamp the listed sums.
    task automatic send_saturating(input int col, input int n_runs, input int row_lo);
        for (int k = 0; k < n_runs; k++)
            send_run(col, $urandom_range(row_lo, COORD_MAX), $urandom_range(1900, LEN_MAX),
                     k == n_runs - 1);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        run_ch.valid         = 1'b0;
        run_ch.run_col       = '0;
        run_ch.run_first_row = '0;
        run_ch.run_len       = '0;
        run_ch.run_last      = 1'b0;
        tx_idle_pct          = 0;
        rx_idle_pct          = 0;
        hold_requests        = 0;
        runs_sent            = 0;
        centre_writes        = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners of the coordinate space, zero length, past the image edge
        set_centre(0, 0);
        send_run(0, 0, 1, 1'b1);
        send_run(COORD_MAX, COORD_MAX, 1, 1'b1);
        send_run(COORD_MAX, 0, IMAGE_SIDE, 1'b1);
        send_run(0, 0, 0, 1'b1);
        send_run(7, 20, 0, 1'b0);
        send_run(7, 20, 5, 1'b0);
        send_run(600, 100, 300, 1'b1);
        send_run(COORD_MAX, COORD_MAX, LEN_MAX, 1'b1);
        send_run(0, 1000, LEN_MAX, 1'b0);
        send_run(COORD_MAX, 0, IMAGE_SIDE, 1'b1);
        stop_runs();
        drain();

        // centre at the far corner: negative offsets on both axes
        set_centre(COORD_MAX, COORD_MAX);
        send_run(0, 0, IMAGE_SIDE, 1'b0);
        send_run(COORD_MAX, 0, IMAGE_SIDE, 1'b0);
        send_run(0, COORD_MAX, 1, 1'b1);
        send_run(COORD_MAX, COORD_MAX, 1, 1'b1);
        send_run(512, 511, 1, 1'b1);
        send_run(COORD_MAX, 500, LEN_MAX, 1'b1);
        stop_runs();
        drain();

        tx_idle_pct = 9;
        rx_idle_pct = 47;
        set_centre($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        send_regions(60);
        stop_runs();
        drain();

        tx_idle_pct = 47;
        rx_idle_pct = 9;
        set_centre(COORD_MAX, 0);
        send_regions(60);
        stop_runs();
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_centre(0, COORD_MAX);
        // result side stalls while single-run regions keep coming
        hold_requests++;
        for (int k = 0; k < 12; k++)
            send_run($urandom_range(0, COORD_MAX), $urandom_range(0, 990),
                     $urandom_range(1, 32), 1'b1);
        send_regions(60);
        stop_runs();
        drain();

        // row sum, m11 and m02 clamp at their upper bounds
        set_centre(0, 0);
        send_saturating(COORD_MAX, 300, COORD_MAX);
        stop_runs();
        drain();

        $display("Covered %0d runs in %0d checked regions over %0d centre settings,",
                 runs_sent, region_count, centre_writes);
        $display("including result back-pressure and a region clamped at its upper bounds.");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
